/* design/stepper_ramp_step_generator_macros.svh */
// Assertion macros of the stepper ramp step generator, used by its controller.
`ifndef STEPPER_RAMP_STEP_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_STEP_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SRSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/srsg_pkg.sv */
// Package with shared constants and types of the stepper ramp step generator.
`timescale 1ns / 1ps
package srsg_pkg;

    localparam int DIST_W    = 32;
    localparam int CFG_W     = 16;
    localparam int MM_W      = 22;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Action codes of an input word.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_GO   = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEP_DIST = 2'd0;
    localparam logic [1:0] CFG_MAX_WAIT  = 2'd1;
    localparam logic [1:0] CFG_DIVISOR   = 2'd2;
    localparam logic [1:0] CFG_STEP_MODE = 2'd3;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_STEP_DIST = 16'd5;
    localparam logic [CFG_W-1:0] RST_MAX_WAIT  = 16'd20;
    localparam logic [CFG_W-1:0] RST_DIVISOR   = 16'd50;
    localparam logic [1:0]       RST_STEP_MODE = 2'd3;

    // Commands from the controller to the datapath and output stage.
    typedef struct packed {
        logic apply;
        logic div_load;
        logic div_step;
        logic reload;
        logic out_load;
    } srsg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_last;
    } srsg_sts_t;

endpackage

/* design/srsg_ctrl.sv */
// Controller state machine that sequences item handling and the ramp divide.
`timescale 1ns / 1ps
`include "stepper_ramp_step_generator_macros.svh"
module srsg_ctrl
    import srsg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    input  srsg_sts_t sts,
    output srsg_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PREP   = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_RELOAD = 5'b01000,
        ST_FINISH = 5'b10000
    } srsg_state_t;

    srsg_state_t state_reg;
    srsg_state_t state_next;
    logic        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.need_div ? ST_PREP : ST_FINISH;
                end
            end
            ST_PREP:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_RELOAD;
                end
            end
            ST_RELOAD: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.apply    = accept;
        cmd.div_load = (state_reg == ST_PREP);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.reload   = (state_reg == ST_RELOAD);
        cmd.out_load = (state_reg == ST_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SRSG_ASSERT_NEXT(a_div_entry, clk, rst_n, accept && sts.need_div, state_reg == ST_PREP, "tick that lowers step did not start the divide")
    `SRSG_ASSERT_NEXT(a_div_exit, clk, rst_n, cmd.div_step && sts.div_last, cmd.reload, "divide end not followed by wait reload")
    `SRSG_ASSERT_NEXT(a_hold_result, clk, rst_n, (state_reg == ST_FINISH) && !out_free, state_reg == ST_FINISH, "result dropped while output slot full")
    `SRSG_ASSERT_NOW(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.apply, cmd.div_load, cmd.div_step, cmd.reload, cmd.out_load}), "overlapping datapath commands")

endmodule

/* design/srsg_datapath.sv */
// Datapath with distance, wait and line state plus the iterative ramp divider.
`timescale 1ns / 1ps
module srsg_datapath
    import srsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  srsg_cmd_t         cmd,
    input  logic [1:0]        action,
    input  logic [MM_W-1:0]   distance_mm,
    input  logic [CFG_W-1:0]  step_distance_um,
    input  logic [CFG_W-1:0]  ramp_max_wait,
    input  logic [CFG_W-1:0]  ramp_divisor,
    output srsg_sts_t         sts,
    output logic              step_out,
    output logic              enable_out,
    output logic [DIST_W-1:0] remaining_dist,
    output logic [DIST_W-1:0] travelled_dist
);

    logic [DIST_W-1:0]    rem_reg, rem_next;
    logic [DIST_W-1:0]    trav_reg, trav_next;
    logic [CFG_W-1:0]     wait_reg, wait_next;
    logic                 step_reg, step_next;
    logic                 en_reg, en_next;

    logic [DIST_W-1:0]    quo_reg, quo_next;
    logic [CFG_W-1:0]     part_reg, part_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [DIST_W:0]      rem_diff;
    logic [DIST_W:0]      trav_sum;
    logic [DIST_W-1:0]    dist_um;
    logic [CFG_W-1:0]     wait_clamp;
    logic [CFG_W:0]       trial;
    logic [CFG_W:0]       trial_diff;
    logic                 trial_ge;

    assign rem_diff = {1'b0, rem_reg} - {{(DIST_W - CFG_W + 1){1'b0}}, step_distance_um};
    assign trav_sum = {1'b0, trav_reg} + {{(DIST_W - CFG_W + 1){1'b0}}, step_distance_um};

    // Millimetres to micrometres: times 1000 is 1024 - 16 - 8.
    assign dist_um = ({{(DIST_W - MM_W){1'b0}}, distance_mm} << 10)
                   - ({{(DIST_W - MM_W){1'b0}}, distance_mm} << 4)
                   - ({{(DIST_W - MM_W){1'b0}}, distance_mm} << 3);

    assign wait_clamp = (wait_reg > ramp_max_wait) ? ramp_max_wait : wait_reg;

    // One restoring divide step; a zero divisor yields an all-ones quotient.
    assign trial      = {part_reg, quo_reg[DIST_W-1]};
    assign trial_ge   = (trial >= {1'b0, ramp_divisor});
    assign trial_diff = trial - {1'b0, ramp_divisor};

    assign sts.need_div = (action == ACT_TICK) && (rem_reg != '0) && step_reg;
    assign sts.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        rem_next  = rem_reg;
        trav_next = trav_reg;
        wait_next = wait_reg;
        step_next = step_reg;
        en_next   = en_reg;

        if (cmd.apply)
        begin
            case (action)
                ACT_TICK:
                begin
                    if (rem_reg == '0)
                    begin
                        en_next = 1'b0;
                    end
                    else if (step_reg)
                    begin
                        step_next = 1'b0;
                        rem_next  = rem_diff[DIST_W] ? '0 : rem_diff[DIST_W-1:0];
                        trav_next = trav_sum[DIST_W] ? '1 : trav_sum[DIST_W-1:0];
                    end
                    else if (wait_clamp == '0)
                    begin
                        wait_next = wait_clamp;
                        step_next = 1'b1;
                    end
                    else
                    begin
                        wait_next = wait_clamp - CFG_W'(1);
                    end
                end
                ACT_GO:
                begin
                    rem_next  = dist_um;
                    trav_next = '0;
                    en_next   = 1'b1;
                    step_next = 1'b1;
                end
                ACT_STOP:
                begin
                    en_next   = 1'b0;
                    rem_next  = '0;
                    trav_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.reload)
        begin
            wait_next = (quo_reg >= {{(DIST_W - CFG_W){1'b0}}, ramp_max_wait})
                      ? '0 : ramp_max_wait - quo_reg[CFG_W-1:0];
        end
    end

    always_comb
    begin
        quo_next  = quo_reg;
        part_next = part_reg;
        cnt_next  = cnt_reg;
        if (cmd.div_load)
        begin
            quo_next  = (rem_reg < trav_reg) ? rem_reg : trav_reg;
            part_next = '0;
            cnt_next  = '0;
        end
        else if (cmd.div_step)
        begin
            quo_next  = {quo_reg[DIST_W-2:0], trial_ge};
            part_next = trial_ge ? trial_diff[CFG_W-1:0] : trial[CFG_W-1:0];
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            trav_reg <= '0;
            wait_reg <= '0;
            step_reg <= 1'b0;
            en_reg   <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            trav_reg <= trav_next;
            wait_reg <= wait_next;
            step_reg <= step_next;
            en_reg   <= en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        part_reg <= part_next;
        cnt_reg  <= cnt_next;
    end

    assign step_out       = step_reg;
    assign enable_out     = en_reg;
    assign remaining_dist = rem_reg;
    assign travelled_dist = trav_reg;

endmodule

/* design/stepper_ramp_step_generator.sv */
// Top level of the stepper ramp step generator: config registers and output word.
`timescale 1ns / 1ps
// Go, stop, unused and counting ticks pass from acceptance straight to the finish state.
// A tick that lowers the step line first passes prep, the 32 one-bit iterations
// of the restoring divider that computes the ramp wait reload, and the reload state.
// One input word is in work at a time; the next is taken as soon as the result is registered.
// Reset (rst_n, asynchronous, active low) clears distances, wait, step and enable lines,
// and loads the configuration defaults: step 5 um, max wait 20, divisor 50, eighth stepping.
module stepper_ramp_step_generator
    import srsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [MM_W-1:0]   distance_mm,

    output logic              out_valid,
    input  logic              out_ready,
    output logic              step_level,
    output logic              driver_enabled,
    output logic              ms1_level,
    output logic              ms2_level,
    output logic [DIST_W-1:0] remaining_um,
    output logic [DIST_W-1:0] travelled_um
);

    // Config registers take every write; user must issue them only while idle, unchecked.
    logic [CFG_W-1:0]  step_dist_reg;
    logic [CFG_W-1:0]  max_wait_reg;
    logic [CFG_W-1:0]  divisor_reg;
    logic [1:0]        step_mode_reg;

    // Result word register, which frees the datapath while a result waits downstream.
    logic              out_valid_reg;
    logic              step_level_reg;
    logic              driver_enabled_reg;
    logic              ms1_level_reg;
    logic              ms2_level_reg;
    logic [DIST_W-1:0] remaining_um_reg;
    logic [DIST_W-1:0] travelled_um_reg;

    srsg_cmd_t         cmd;
    srsg_sts_t         sts;
    logic              out_free;
    logic              step_out;
    logic              enable_out;
    logic [DIST_W-1:0] remaining_dist;
    logic [DIST_W-1:0] travelled_dist;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_dist_reg <= RST_STEP_DIST;
            max_wait_reg  <= RST_MAX_WAIT;
            divisor_reg   <= RST_DIVISOR;
            step_mode_reg <= RST_STEP_MODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP_DIST: step_dist_reg <= cfg_data;
                CFG_MAX_WAIT:  max_wait_reg  <= cfg_data;
                CFG_DIVISOR:   divisor_reg   <= cfg_data;
                CFG_STEP_MODE: step_mode_reg <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The output slot can take a new word when it is empty or being drained this cycle.
    assign out_free = !out_valid_reg || out_ready;

    srsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    srsg_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .action           (action),
        .distance_mm      (distance_mm),
        .step_distance_um (step_dist_reg),
        .ramp_max_wait    (max_wait_reg),
        .ramp_divisor     (divisor_reg),
        .sts              (sts),
        .step_out         (step_out),
        .enable_out       (enable_out),
        .remaining_dist   (remaining_dist),
        .travelled_dist   (travelled_dist)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The microstep pins follow step_mode bit for bit.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            step_level_reg     <= step_out;
            driver_enabled_reg <= enable_out;
            ms1_level_reg      <= step_mode_reg[0];
            ms2_level_reg      <= step_mode_reg[1];
            remaining_um_reg   <= remaining_dist;
            travelled_um_reg   <= travelled_dist;
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_level     = step_level_reg;
    assign driver_enabled = driver_enabled_reg;
    assign ms1_level      = ms1_level_reg;
    assign ms2_level      = ms2_level_reg;
    assign remaining_um   = remaining_um_reg;
    assign travelled_um   = travelled_um_reg;

endmodule

/* dv/stepper_ramp_step_generator_test.sv */
// Self-checking testbench of the stepper ramp step generator with a predicting scoreboard.
`timescale 1ns / 1ps
module stepper_ramp_step_generator_test;
    import srsg_pkg::*;

    // The fourth action code has no meaning; the block must leave its state alone.
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [DIST_W-1:0] UM_PER_MM = 32'd1000;

    // Slowest correct run: about 1700 words, each with its divide work, plus random sender
    // gaps and receiver stalls, plus the long hold-off; the limit leaves a wide margin.
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_WORDS  = 150;

    typedef struct {
        logic              step;
        logic              enabled;
        logic              ms1;
        logic              ms2;
        logic [DIST_W-1:0] remaining;
        logic [DIST_W-1:0] travelled;
    } motion_word_t;

    // Tracks the motion state of the generator and queues the output word that each
    // accepted command should produce.
    class motion_board;
        logic [CFG_W-1:0]  step_um;
        logic [CFG_W-1:0]  max_wait;
        logic [CFG_W-1:0]  divisor;
        logic [1:0]        mode;
        logic [DIST_W-1:0] remaining;
        logic [DIST_W-1:0] travelled;
        logic [CFG_W-1:0]  wait_ticks;
        logic              step_line;
        logic              enable_line;
        motion_word_t      due_words[$];
        int                failures;

        function new();
            step_um     = RST_STEP_DIST;
            max_wait    = RST_MAX_WAIT;
            divisor     = RST_DIVISOR;
            mode        = RST_STEP_MODE;
            remaining   = '0;
            travelled   = '0;
            wait_ticks  = '0;
            step_line   = 1'b0;
            enable_line = 1'b0;
            failures    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_STEP_DIST: step_um  = value;
                CFG_MAX_WAIT:  max_wait = value;
                CFG_DIVISOR:   divisor  = value;
                CFG_STEP_MODE: mode     = value[1:0];
                default: ;
            endcase
        endfunction

        // One timer tick of the pulse engine.
        function void advance_tick();
            logic [DIST_W-1:0] near_end;
            logic [DIST_W-1:0] less;
            logic [DIST_W:0]   sum;
            if (remaining == '0) begin
                enable_line = 1'b0;
                return;
            end
            if (step_line) begin
                step_line = 1'b0;
                remaining = (remaining > DIST_W'(step_um)) ? remaining - DIST_W'(step_um) : '0;
                sum = {1'b0, travelled} + {{(DIST_W - CFG_W + 1){1'b0}}, step_um};
                travelled = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
                near_end = (remaining < travelled) ? remaining : travelled;
                // A zero divisor behaves like a divider answering all ones.
                less = (divisor == '0) ? '1 : near_end / DIST_W'(divisor);
                wait_ticks = (less >= DIST_W'(max_wait)) ? '0
                                                         : max_wait - less[CFG_W-1:0];
                return;
            end
            if (wait_ticks > max_wait)
                wait_ticks = max_wait;
            if (wait_ticks == '0)
                step_line = 1'b1;
            else
                wait_ticks = wait_ticks - CFG_W'(1);
        endfunction

        function void note_command(logic [1:0] act, logic [MM_W-1:0] mm);
            motion_word_t w;
            case (act)
                ACT_TICK: advance_tick();
                ACT_GO:
                begin
                    remaining   = DIST_W'(mm) * UM_PER_MM;
                    travelled   = '0;
                    enable_line = 1'b1;
                    step_line   = 1'b1;
                end
                ACT_STOP:
                begin
                    enable_line = 1'b0;
                    remaining   = '0;
                    travelled   = '0;
                end
                default: ;
            endcase
            w.step      = step_line;
            w.enabled   = enable_line;
            w.ms1       = mode[0];
            w.ms2       = mode[1];
            w.remaining = remaining;
            w.travelled = travelled;
            due_words.push_back(w);
        endfunction

        function void check_field(string field, logic [DIST_W-1:0] want,
                                  logic [DIST_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_word(logic step, logic en, logic ms1, logic ms2,
                                 logic [DIST_W-1:0] rem, logic [DIST_W-1:0] trav);
            motion_word_t w;
            if (due_words.size() == 0) begin
                $error("output word with no command waiting for it");
                failures++;
                return;
            end
            w = due_words.pop_front();
            check_field("step_level", DIST_W'(w.step), DIST_W'(step));
            check_field("driver_enabled", DIST_W'(w.enabled), DIST_W'(en));
            check_field("ms1_level", DIST_W'(w.ms1), DIST_W'(ms1));
            check_field("ms2_level", DIST_W'(w.ms2), DIST_W'(ms2));
            check_field("remaining_um", w.remaining, rem);
            check_field("travelled_um", w.travelled, trav);
        endfunction

        function int pending();
            return due_words.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        action;
    logic [MM_W-1:0]   distance_mm;
    logic              out_valid;
    logic              out_ready;
    logic              step_level;
    logic              driver_enabled;
    logic              ms1_level;
    logic              ms2_level;
    logic [DIST_W-1:0] remaining_um;
    logic [DIST_W-1:0] travelled_um;

    motion_board board = new();

    // Random idling on both sides is on until the last phase of the run.
    bit idling_on = 1'b1;
    // Set by the stimulus once, mid-run; the output side then holds off for a long stretch.
    bit hold_output = 1'b0;
    // Step size currently programmed, used to pick distances that finish in a few steps.
    int unsigned cur_step_um = 32'(RST_STEP_DIST);
    int unsigned cycle_count = 0;

    stepper_ramp_step_generator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .distance_mm    (distance_mm),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .step_level     (step_level),
        .driver_enabled (driver_enabled),
        .ms1_level      (ms1_level),
        .ms2_level      (ms2_level),
        .remaining_um   (remaining_um),
        .travelled_um   (travelled_um)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output monitor. Values are sampled at the edge, before any nonblocking update lands.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_word(step_level, driver_enabled, ms1_level, ms2_level,
                             remaining_um, travelled_um);
    end

    // Output side back-pressure: short random stalls, plus one long hold-off on request
    // so that the block fills up and has to refuse new input words.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_output) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Offers one command word and waits until the block takes it. Valid is left high so
    // that a following word keeps the line up without a glitch.
    task automatic send_word(logic [1:0] act, logic [MM_W-1:0] mm);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        distance_mm <= mm;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_command(act, mm);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, value);
    endtask

    // Registers are only touched once every output word of the previous phase is back.
    task automatic configure(logic [CFG_W-1:0] step_um, logic [CFG_W-1:0] max_wait,
                             logic [CFG_W-1:0] divisor, logic [1:0] mode);
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        write_reg(CFG_STEP_DIST, step_um);
        write_reg(CFG_MAX_WAIT, max_wait);
        write_reg(CFG_DIVISOR, divisor);
        write_reg(CFG_STEP_MODE, mode);
        cfg_valid <= 1'b0;
        cur_step_um = 32'(step_um);
    endtask

    function automatic logic [MM_W-1:0] any_mm();
        return MM_W'($urandom_range(0, (1 << MM_W) - 1));
    endfunction

    // Mostly distances that take only a handful of steps, so moves reach their end.
    function automatic logic [MM_W-1:0] pick_distance();
        if ($urandom_range(0, 9) == 0)
            return any_mm();
        return MM_W'($urandom_range(0, 1 + cur_step_um * 8 / 1000));
    endfunction

    // Extremes at reset settings: idle ticks, zero and full distances, stop mid-wait,
    // the spare action code, and a short move.
    task automatic run_directed();
        send_word(ACT_SPARE, '1);
        send_word(ACT_TICK, '0);
        send_word(ACT_STOP, '1);
        send_word(ACT_GO, '0);
        send_word(ACT_TICK, '0);
        send_word(ACT_GO, '1);
        repeat (4) send_word(ACT_TICK, any_mm());
        send_word(ACT_SPARE, '0);
        send_word(ACT_STOP, '0);
        send_word(ACT_TICK, '0);
        send_word(ACT_GO, 22'd1);
        repeat (8) send_word(ACT_TICK, '0);
        send_word(ACT_GO, 22'h2AAAAA);
        send_word(ACT_GO, 22'h155555);
        send_word(ACT_STOP, '0);
    endtask

    // Mostly well-formed moves (a go followed by a run of ticks), with stops, spare codes
    // and fully random words mixed in. Spare words do not count toward the budget.
    task automatic run_phase(int budget, bit with_hold);
        int sent;
        int burst;
        int roll;
        logic [1:0] act;
        sent = 0;
        // Ticks first, so a wait left over from the old settings meets the new maximum.
        repeat (3) send_word(ACT_TICK, any_mm());
        sent = 3;
        while (sent < budget) begin
            if (with_hold && sent > budget / 2 && !hold_output) begin
                hold_output = 1'b1;
                with_hold = 1'b0;
            end
            if ($urandom_range(0, 99) < 85) begin
                send_word(ACT_GO, pick_distance());
                sent++;
                burst = $urandom_range(8, 60);
                repeat (burst) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 2) begin
                        send_word(ACT_STOP, any_mm());
                        sent++;
                    end else if (roll < 4) begin
                        send_word(ACT_SPARE, any_mm());
                    end else begin
                        send_word(ACT_TICK, any_mm());
                        sent++;
                    end
                end
            end else begin
                act = 2'($urandom_range(0, 3));
                send_word(act, any_mm());
                if (act != ACT_SPARE)
                    sent++;
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] step_um;
        logic [CFG_W-1:0] max_wait;
        logic [CFG_W-1:0] divisor;

        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_STEP_DIST;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        action      <= ACT_TICK;
        distance_mm <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                // Huge steps, no ramp, full stepping.
                0: configure(16'hFFFF, 16'd0, 16'd1, 2'd0);
                // Tiny steps with the longest wait and the largest divisor.
                1: configure(16'd1, 16'hFFFF, 16'hFFFF, 2'd1);
                // Zero step size never moves; zero divisor gives no ramp.
                2: configure(16'd0, 16'd3, 16'd0, 2'd2);
                3: configure(16'd700, 16'd5, 16'd1, 2'd3);
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: step_um = '0;
                        1: step_um = '1;
                        default: step_um = CFG_W'($urandom_range(100, 65535));
                    endcase
                    max_wait = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 65535))
                                                           : CFG_W'($urandom_range(0, 6));
                    case ($urandom_range(0, 9))
                        0: divisor = '0;
                        1, 2, 3, 4: divisor = CFG_W'($urandom_range(1, 500));
                        default: divisor = CFG_W'($urandom_range(1, 65535));
                    endcase
                    configure(step_um, max_wait, divisor, 2'($urandom_range(0, 3)));
                end
            endcase
            // The final phase runs without any idling on either side.
            if (phase == PHASE_COUNT - 1)
                idling_on = 1'b0;
            run_phase(PHASE_WORDS, phase == 5);
        end

        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
